/* rtl/egg_drop_min_trials_macros.svh */
// Assertion macros shared by the egg drop block.
`ifndef EGG_DROP_MIN_TRIALS_MACROS_SVH
`define EGG_DROP_MIN_TRIALS_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define EDMT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define EDMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `EDMT_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define EDMT_ASSERT(lbl, clk, rstn, prop, msg)
`define EDMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/edmt_pkg.sv */
// Package with field widths and the control state type of the egg drop block.
`timescale 1ns / 1ps
`default_nettype none
package edmt_pkg;

    localparam int EGGS_W   = 5;
    localparam int FLOORS_W = 9;
    localparam int TRIALS_W = 9;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int TRIALS_MAX = 511;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage
`default_nettype wire

/* rtl/edmt_row_store.sv */
// Two row memories of the trials table, swapped between previous and current row.
`timescale 1ns / 1ps
`default_nettype none
module edmt_row_store #(
    parameter int DEPTH = 257,
    parameter int AW    = 9,
    parameter int DW    = 9
) (
    input  wire logic          clk,
    input  wire logic          cur_sel,
    input  wire logic [AW-1:0] addr_prev,
    input  wire logic [AW-1:0] addr_cur,
    input  wire logic          wr_en,
    input  wire logic          wr_sel,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    output logic      [DW-1:0] q_prev,
    output logic      [DW-1:0] q_cur
);

    logic [DW-1:0] mem0 [DEPTH];
    logic [DW-1:0] mem1 [DEPTH];
    logic [DW-1:0] q0_reg;
    logic [DW-1:0] q1_reg;
    logic          sel_reg;
    logic [AW-1:0] addr0;
    logic [AW-1:0] addr1;

    // the current row lives in the memory picked by cur_sel
    assign addr0 = cur_sel ? addr_prev : addr_cur;
    assign addr1 = cur_sel ? addr_cur : addr_prev;

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_sel)
        begin
            mem0[wr_addr] <= wr_data;
        end
        q0_reg <= mem0[addr0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_sel)
        begin
            mem1[wr_addr] <= wr_data;
        end
        q1_reg <= mem1[addr1];
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= cur_sel;
    end

    assign q_prev = sel_reg ? q0_reg : q1_reg;
    assign q_cur  = sel_reg ? q1_reg : q0_reg;

endmodule
`default_nettype wire

/* rtl/egg_drop_min_trials.sv */
// Top level of the egg drop minimum trials block.
//
//  channel   dir  fields (tdata, lowest bit up)          transfer
//  s_axis    in   eggs[4:0], floors[13:5], zero pad      tvalid & tready
//  m_axis    out  trials[8:0], zero pad                  tvalid & tready
//
// With one egg or at most one floor the control goes straight to the done state and the
// result is then registered for output. Otherwise each egg row from two up to eggs walks
// every floor count j from 2 to floors, one compare per drop floor plus one write-back
// bubble per count. Reset clears the control state; the row memories are not cleared,
// since every entry read is written earlier in the same item.
// The output register holds a finished result while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "egg_drop_min_trials_macros.svh"
module egg_drop_min_trials #(
    parameter int MAX_EGGS   = 16,
    parameter int MAX_FLOORS = 256
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // eggs [4:0], floors [13:5], zero [15:14]
    input  wire logic [edmt_pkg::IN_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // trials [8:0], zero [15:9]
    output logic [edmt_pkg::OUT_W-1:0]     m_axis_tdata
);

    import edmt_pkg::*;

    // floor counts, addresses and table values share one width
    localparam int FW_RAW = $clog2(MAX_FLOORS + 1);
    localparam int FW     = (FW_RAW > 2) ? FW_RAW : 2;
    localparam int EW_RAW = $clog2(MAX_EGGS + 1);
    localparam int EW     = (EW_RAW > 2) ? EW_RAW : 2;
    localparam int CW     = (FW > FLOORS_W) ? FW : FLOORS_W;
    localparam int EC     = (EW > EGGS_W) ? EW : EGGS_W;
    localparam int DEPTH  = MAX_FLOORS + 1;

    state_t        state_reg, state_next;
    logic [EW-1:0] eggs_reg;
    logic [FW-1:0] floors_reg;
    logic [EW-1:0] e_reg;
    logic [FW-1:0] j_reg;
    logic [FW-1:0] x_reg;
    logic [FW-1:0] best_reg;
    logic [TRIALS_W-1:0] res_reg;
    logic          out_valid_reg;
    logic [TRIALS_W-1:0] out_data_reg;

    // compare stage, aligned with the memory read data
    logic          p_valid_reg;
    logic          p_first_reg;
    logic          p_last_reg;
    logic          p_final_reg;
    logic          p_sel_reg;
    logic [FW-1:0] p_j_reg;
    logic          p_a_byp_reg;
    logic          p_b_byp_reg;
    logic [FW-1:0] p_a_val_reg;
    logic [FW-1:0] p_b_val_reg;

    logic [EC-1:0] eggs_in;
    logic [CW-1:0] floors_in;
    logic [EW-1:0] eggs_sat;
    logic [FW-1:0] floors_sat;
    logic          in_xfer;
    logic          issue;
    logic [FW-1:0] addr_prev;
    logic [FW-1:0] addr_cur;
    logic [FW-1:0] q_prev;
    logic [FW-1:0] q_cur;
    logic [FW-1:0] a_val;
    logic [FW-1:0] b_val;
    logic [FW-1:0] cand;
    logic [FW-1:0] best_in;
    logic          out_free;

    function automatic logic [TRIALS_W-1:0] sat_trials(input logic [FW-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext > CW'(TRIALS_MAX))
        begin
            sat_trials = TRIALS_W'(TRIALS_MAX);
        end
        else
        begin
            sat_trials = ext[TRIALS_W-1:0];
        end
    endfunction

    // clamp the input fields into the table range
    always_comb
    begin
        eggs_in   = EC'(s_axis_tdata[EGGS_W-1:0]);
        floors_in = CW'(s_axis_tdata[EGGS_W+FLOORS_W-1:EGGS_W]);
        if (eggs_in == '0)
        begin
            eggs_sat = EW'(1);
        end
        else if (eggs_in > EC'(MAX_EGGS))
        begin
            eggs_sat = EW'(MAX_EGGS);
        end
        else
        begin
            eggs_sat = eggs_in[EW-1:0];
        end
        if (floors_in > CW'(MAX_FLOORS))
        begin
            floors_sat = FW'(MAX_FLOORS);
        end
        else
        begin
            floors_sat = floors_in[FW-1:0];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // hold issue back while the last drop floor of a count is in the compare stage,
    // so the next count reads the entry just written back
    assign issue = (state_reg == ST_RUN) && !(p_valid_reg && p_last_reg);

    assign addr_prev = x_reg - FW'(1);
    assign addr_cur  = j_reg - x_reg;

    edmt_row_store #(
        .DEPTH (DEPTH),
        .AW    (FW),
        .DW    (FW)
    ) u_rows (
        .clk       (clk),
        .cur_sel   (e_reg[0]),
        .addr_prev (addr_prev),
        .addr_cur  (addr_cur),
        .wr_en     (p_valid_reg && p_last_reg),
        .wr_sel    (p_sel_reg),
        .wr_addr   (p_j_reg),
        .wr_data   (best_in),
        .q_prev    (q_prev),
        .q_cur     (q_cur)
    );

    // one candidate per cycle outside write-back bubbles: 1 + max of the two row entries, then the running minimum
    always_comb
    begin
        a_val = p_a_byp_reg ? p_a_val_reg : q_prev;
        b_val = p_b_byp_reg ? p_b_val_reg : q_cur;
        cand  = ((a_val > b_val) ? a_val : b_val) + FW'(1);
        if (p_first_reg || (cand < best_reg))
        begin
            best_in = cand;
        end
        else
        begin
            best_in = best_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((eggs_sat == EW'(1)) || (floors_sat <= FW'(1)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (p_valid_reg && p_final_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and loop counters
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            eggs_reg   <= eggs_sat;
            floors_reg <= floors_sat;
            e_reg      <= EW'(2);
            j_reg      <= FW'(2);
            x_reg      <= FW'(1);
            res_reg    <= sat_trials(floors_sat);
        end
        else if (issue)
        begin
            if (x_reg == j_reg)
            begin
                x_reg <= FW'(1);
                if (j_reg == floors_reg)
                begin
                    j_reg <= FW'(2);
                    e_reg <= e_reg + EW'(1);
                end
                else
                begin
                    j_reg <= j_reg + FW'(1);
                end
            end
            else
            begin
                x_reg <= x_reg + FW'(1);
            end
        end

        // entries at zero and one floor, and the whole one-egg row, are known values
        p_first_reg <= (x_reg == FW'(1));
        p_last_reg  <= (x_reg == j_reg);
        p_final_reg <= (x_reg == j_reg) && (j_reg == floors_reg) && (e_reg == eggs_reg);
        p_sel_reg   <= e_reg[0];
        p_j_reg     <= j_reg;
        p_a_byp_reg <= (e_reg == EW'(2)) || (addr_prev <= FW'(1));
        p_b_byp_reg <= (addr_cur <= FW'(1));
        p_a_val_reg <= addr_prev;
        p_b_val_reg <= addr_cur;

        if (p_valid_reg)
        begin
            best_reg <= best_in;
            if (p_final_reg)
            begin
                res_reg <= sat_trials(best_in);
            end
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - TRIALS_W)'(0), out_data_reg};

    `EDMT_ASSERT(a_stage_in_run, clk, rst_n, p_valid_reg |-> (state_reg == ST_RUN), "compare stage busy outside run")
    `EDMT_ASSERT(a_wb_bubble, clk, rst_n, (p_valid_reg && p_last_reg) |=> !p_valid_reg, "no bubble after write-back")
    `EDMT_ASSERT_NEVER(a_issue_in_idle, clk, rst_n, issue && (state_reg != ST_RUN), "issue outside run")

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the egg drop minimum trials block.
`timescale 1ns / 1ps
module tb;
    import edmt_pkg::*;

    localparam int EGG_LIMIT   = 16;
    localparam int FLOOR_LIMIT = 256;
    // Long receiver hold that backs results up into the input side.
    localparam int BACKLOG_CYCLES = 3000;
    // Allowance per item for sender gaps, receiver stalls and pipeline cycles.
    localparam int ITEM_SLACK = 60;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [FLOORS_W-1:0] floors;
        logic [EGGS_W-1:0]   eggs;
    } drop_req_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // eggs [4:0], floors [13:5], zero [15:14]
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // trials [8:0], zero [15:9]
    logic [OUT_W-1:0]    m_axis_tdata;

    drop_req_t           pending_drops[$];
    logic [TRIALS_W-1:0] expected_trials[$];
    longint              cycle_budget = 0;
    longint              cycle_count  = 0;
    int                  mismatch_count = 0;
    int                  results_seen = 0;

    // Sender pacing.
    int                  burst_left = 0;
    int                  gap_left   = 0;
    // Receiver pacing.
    int                  hold_left  = 0;
    logic                hold_done  = 1'b0;
    logic [15:0]         ready_pattern = 16'hffff;

    egg_drop_min_trials #(
        .MAX_EGGS   (EGG_LIMIT),
        .MAX_FLOORS (FLOOR_LIMIT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Worst-case trials by the two-row table: clamp eggs (zero counts as one)
    // and floors, seed the one-egg row, then build each further egg row.
    function automatic logic [TRIALS_W-1:0] min_trials_for(input logic [EGGS_W-1:0] eggs_in,
                                                          input logic [FLOORS_W-1:0] floors_in);
        int fewer_row [0:FLOOR_LIMIT];
        int cur_row [0:FLOOR_LIMIT];
        int n_eggs;
        int n_floors;
        int best;
        int worse;
        int answer;
        n_eggs   = (eggs_in == 0) ? 1 : ((eggs_in > EGG_LIMIT) ? EGG_LIMIT : int'(eggs_in));
        n_floors = (floors_in > FLOOR_LIMIT) ? FLOOR_LIMIT : int'(floors_in);
        for (int j = 0; j <= n_floors; j++)
            fewer_row[j] = j;
        for (int e = 2; e <= n_eggs; e++)
        begin
            cur_row[0] = 0;
            if (n_floors >= 1)
                cur_row[1] = 1;
            for (int j = 2; j <= n_floors; j++)
            begin
                best = 32'h7fff_ffff;
                for (int x = 1; x <= j; x++)
                begin
                    // egg breaks: x-1 floors below with one egg fewer; survives: j-x above
                    worse = (fewer_row[x - 1] > cur_row[j - x]) ? fewer_row[x - 1]
                                                                : cur_row[j - x];
                    if (worse + 1 < best)
                        best = worse + 1;
                end
                cur_row[j] = best;
            end
            for (int j = 0; j <= n_floors; j++)
                fewer_row[j] = cur_row[j];
        end
        answer = fewer_row[n_floors];
        if (answer > TRIALS_MAX)
            answer = TRIALS_MAX;
        return answer[TRIALS_W-1:0];
    endfunction

    // Queue one request and grow the run limit by its worst-case compute time.
    task automatic add_drop(input int eggs_val, input int floors_val);
        drop_req_t req;
        longint    e_eff;
        longint    f_eff;
        req.eggs   = eggs_val[EGGS_W-1:0];
        req.floors = floors_val[FLOORS_W-1:0];
        pending_drops.push_back(req);
        e_eff = (eggs_val == 0) ? 1 : ((eggs_val > EGG_LIMIT) ? EGG_LIMIT : eggs_val);
        f_eff = (floors_val > FLOOR_LIMIT) ? FLOOR_LIMIT : floors_val;
        cycle_budget += (e_eff - 1) * f_eff * (f_eff + 3) / 2 + f_eff + ITEM_SLACK;
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int n_eggs;
        int n_floors;
        int n_items;

        // Trivial rows first: no floors, one floor, one egg.
        add_drop(1, 0);
        add_drop(1, 1);
        add_drop(2, 0);
        add_drop(2, 1);
        // Zero eggs behaves like one egg.
        add_drop(0, 10);
        add_drop(2, 10);
        add_drop(3, 14);
        // Egg counts past the table clamp to the largest row.
        add_drop(31, 2);
        add_drop(16, 1);
        add_drop(17, 12);
        add_drop(5, 16);
        add_drop(1, 256);
        // Floor counts past the table clamp to the last column.
        add_drop(1, 511);
        add_drop(0, 300);
        add_drop(31, 20);
        add_drop(2, 100);
        add_drop(2, 257);
        // Full table: every egg row across every floor count.
        add_drop(16, 256);

        // Random part: mostly short buildings, now and then a tall one with few eggs.
        for (int i = 0; i < 100; i++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                n_eggs   = $urandom_range(0, 2);
                n_floors = $urandom_range(17, 511);
            end
            else
            begin
                n_eggs   = $urandom_range(0, 31);
                n_floors = $urandom_range(0, 16);
            end
            add_drop(n_eggs, n_floors);
        end
        n_items = pending_drops.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait until every request has come back, then let the pipe settle.
        while (results_seen < n_items)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Sender: hold an offered transfer until taken, otherwise advance through
    // bursts and gaps of random length.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                void'(pending_drops.pop_front());
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pending_drops.size() != 0)
                begin
                    offer = 1'b1;
                    s_axis_tdata <= {{(IN_W - EGGS_W - FLOORS_W){1'b0}},
                                     pending_drops[0].floors, pending_drops[0].eggs};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 8);
                        // Every fourth burst boundary on average runs straight on.
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // Receiver: one long hold early on to back the block up, then a rotating
    // stall pattern that is re-drawn now and then.
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        logic [15:0] next_pattern;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
            ready_pattern <= 16'hffff;
        end
        else if (!hold_done && results_seen == 3)
        begin
            hold_done     <= 1'b1;
            hold_left     <= BACKLOG_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            next_pattern = {ready_pattern[14:0], ready_pattern[15]};
            if ($urandom_range(0, 63) == 0)
            begin
                // Keep at least one ready bit so the pattern never stalls forever.
                if ($urandom_range(0, 2) == 0)
                    next_pattern = 16'hffff;
                else
                    next_pattern = 16'($urandom()) | 16'h0001;
            end
            ready_pattern <= next_pattern;
            m_axis_tready <= ready_pattern[0];
        end
    end

    // Scoreboard: retire a result against the oldest expectation, then record
    // the expectation for any request taken on this edge.
    always @(posedge clk)
    begin : check_trials
        logic [TRIALS_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_trials.size() == 0)
                begin
                    $error("trials: no result expected, got %0d", m_axis_tdata[TRIALS_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_trials.pop_front();
                    if (m_axis_tdata[TRIALS_W-1:0] !== want)
                    begin
                        $error("trials: expected %0d, got %0d", want,
                               m_axis_tdata[TRIALS_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_trials.push_back(min_trials_for(s_axis_tdata[EGGS_W-1:0],
                                          s_axis_tdata[EGGS_W +: FLOORS_W]));
        end
    end

    // Watchdog: the limit is several times the slowest correct run.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4 * cycle_budget + 4 * BACKLOG_CYCLES + 10000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
